[rtl/core/running_statistics_update_unit_defines.svh]
// Assertion macros for the running statistics update unit.
// No dependencies; included by the RTL files that carry assertions.
`ifndef RUNNING_STATISTICS_UPDATE_UNIT_DEFINES_SVH
`define RUNNING_STATISTICS_UPDATE_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define RSU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rsu_pkg.sv]
// Shared types and constants for the running statistics update unit.
// No dependencies.
`timescale 1ns / 1ps

package rsu_pkg;

  localparam int unsigned DIGIT_W = 32;

  typedef enum logic [1:0] {
    REG_SEED_COUNT     = 2'd0,
    REG_SEED_MEAN      = 2'd1,
    REG_SEED_HARMONIC  = 2'd2,
    REG_SEED_DEVIATION = 2'd3
  } rsu_reg_e;

  typedef struct packed {
    logic busy;
    logic done;
  } rsu_stat_t;

endpackage

[rtl/core/rsu_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on rsu_pkg.
`timescale 1ns / 1ps

module rsu_div #(
  parameter int unsigned NW = 98,
  parameter int unsigned DW = 65
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NW-1:0]     num_i,
  input  logic [DW-1:0]     den_i,
  output logic [NW-1:0]     quot_o,
  output rsu_pkg::rsu_stat_t stat_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] q_q, q_d;
  logic [DW-1:0] rem_q, rem_d, den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [DW:0]   rem_sh, rem_sub;
  logic          ge;

  always_comb begin
    rem_sh  = {rem_q, q_q[NW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = rem_sh >= {1'b0, den_q};
    q_d     = q_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (start_i) begin
      q_d   = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CW'(NW);
    end else if (cnt_q != '0) begin
      q_d    = {q_q[NW-2:0], ge};
      rem_d  = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quot_o      = q_q;
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule

[rtl/core/rsu_isqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on rsu_pkg.
`timescale 1ns / 1ps

module rsu_isqrt #(
  parameter int unsigned VW = 98
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [VW-1:0]      val_i,
  output logic [(VW+1)/2-1:0] root_o,
  output rsu_pkg::rsu_stat_t stat_o
);

  localparam int unsigned SW = (VW + 1) / 2;
  localparam int unsigned CW = $clog2(SW + 1);

  logic [2*SW-1:0] v_q, v_d;
  logic [SW:0]     rem_q, rem_d;
  logic [SW-1:0]   root_q, root_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [SW+2:0]   rem_sh, trial, rem_sub;
  logic            ge;

  always_comb begin
    rem_sh  = {rem_q, v_q[2*SW-1:2*SW-2]};
    trial   = {1'b0, root_q, 2'b01};
    rem_sub = rem_sh - trial;
    ge      = rem_sh >= trial;
    v_d     = v_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (start_i) begin
      v_d    = (2*SW)'(val_i);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CW'(SW);
    end else if (cnt_q != '0) begin
      v_d    = {v_q[2*SW-3:0], 2'b00};
      rem_d  = ge ? rem_sub[SW:0] : rem_sh[SW:0];
      root_d = {root_q[SW-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o      = root_q;
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule

[rtl/core/running_statistics_update_unit.sv]
// Running statistics update unit: count, mean, deviation, RMS and harmonic mean.
// One beat at a time: no new beat is taken until the previous result beat is issued. The
// pace is set by the shared 32x32 multiply-accumulate and the one-bit-per-cycle divider
// and root unit. The accumulator width AW is max(80+FRAC_BITS, 98); the harmonic division
// is skipped when the harmonic result is not valid.
// Reset (async, active low) clears seeds and running state; first beat loads seeds.
// Depends on rsu_pkg, rsu_div, rsu_isqrt and the defines header.
`timescale 1ns / 1ps
`include "running_statistics_update_unit_defines.svh"

module running_statistics_update_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] sample_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] sample_count_o,
  output logic [31:0] std_deviation_o,
  output logic [31:0] arith_mean_o,
  output logic [31:0] quad_mean_o,
  output logic [31:0] harm_mean_o,
  output logic        harm_valid_o
);

  localparam int unsigned XW = 16 + FRAC_BITS;
  localparam int unsigned AW = (64 + XW > 98) ? 64 + XW : 98;
  localparam int unsigned DW = XW + 33;
  localparam int unsigned SW = (AW + 1) / 2;
  localparam int unsigned DG = rsu_pkg::DIGIT_W;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MDD, ST_MMM, ST_MSM, ST_MXX, ST_DE2, ST_MMN, ST_DMN, ST_MNN,
    ST_SQV, ST_MNH, ST_MNX, ST_MDEN, ST_DH, ST_SQW, ST_OUT
  } state_e;

  function automatic logic [31:0] sat32(input logic [AW-1:0] v);
    sat32 = (|v[AW-1:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  state_e        state_q, state_d;
  logic [15:0]   seed_count_q, seed_count_d;
  logic [31:0]   seed_mean_q, seed_mean_d, seed_harm_q, seed_harm_d, seed_dev_q, seed_dev_d;
  logic          first_q, first_d;
  logic [31:0]   cnt_q, cnt_d, mean_q, mean_d, dev_q, dev_d, harm_q, harm_d;
  logic [31:0]   n_q, n_d, m_q, m_d;
  logic [XW-1:0] x_q, x_d;
  logic [95:0]   opa_q, opa_d;
  logic [63:0]   opb_q, opb_d;
  logic [AW-1:0] acc_q, acc_d, wide_q, wide_d;
  logic [2:0]    mk_q, mk_d;
  logic [31:0]   nmean_q, nmean_d, quad_q, quad_d, ndev_q, ndev_d, nharm_q, nharm_d;
  logic          hval_q, hval_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   o_cnt_q, o_cnt_d, o_dev_q, o_dev_d, o_mean_q, o_mean_d;
  logic [31:0]   o_quad_q, o_quad_d, o_harm_q, o_harm_d;
  logic          o_hval_q, o_hval_d;

  logic [31:0]   a_dig, b_dig;
  logic [63:0]   prod;
  logic [1:0]    sh;
  logic [AW-1:0] acc_sum, var_val;
  logic          mac_last;
  logic [DW-1:0] den_val;

  logic               div_start, sq_start;
  logic [AW-1:0]      div_num, div_quot, sq_val;
  logic [DW-1:0]      div_den;
  logic [SW-1:0]      sq_root;
  rsu_pkg::rsu_stat_t div_stat, sq_stat;

  logic          cfg_wr, in_acc;
  logic [31:0]   cur_cnt, cur_mean, cur_dev, cur_harm;

  rsu_div #(.NW(AW), .DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  rsu_isqrt #(.VW(AW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (sq_val),
    .root_o  (sq_root),
    .stat_o  (sq_stat)
  );

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    unique case (rsu_pkg::rsu_reg_e'(paddr[3:2]))
      rsu_pkg::REG_SEED_COUNT:     prdata = {16'd0, seed_count_q};
      rsu_pkg::REG_SEED_MEAN:      prdata = seed_mean_q;
      rsu_pkg::REG_SEED_HARMONIC:  prdata = seed_harm_q;
      rsu_pkg::REG_SEED_DEVIATION: prdata = seed_dev_q;
      default:                     prdata = '0;
    endcase
  end

  // shared 32x32 multiply-accumulate over 3x2 digits
  always_comb begin
    a_dig    = opa_q[DG*mk_q[2:1] +: DG];
    b_dig    = opb_q[DG*mk_q[0] +: DG];
    prod     = a_dig * b_dig;
    sh       = mk_q[2:1] + {1'b0, mk_q[0]};
    acc_sum  = acc_q + (AW'(prod) << (DG * sh));
    mac_last = (mk_q == 3'd5);
    var_val  = (wide_q >= acc_sum) ? wide_q - acc_sum : '0;
    den_val  = acc_sum[DW-1:0];
  end

  always_comb begin
    state_d      = state_q;
    seed_count_d = seed_count_q;
    seed_mean_d  = seed_mean_q;
    seed_harm_d  = seed_harm_q;
    seed_dev_d   = seed_dev_q;
    first_d      = first_q;
    cnt_d        = cnt_q;
    mean_d       = mean_q;
    dev_d        = dev_q;
    harm_d       = harm_q;
    n_d          = n_q;
    m_d          = m_q;
    x_d          = x_q;
    opa_d        = opa_q;
    opb_d        = opb_q;
    acc_d        = acc_q;
    wide_d       = wide_q;
    mk_d         = mk_q;
    nmean_d      = nmean_q;
    quad_d       = quad_q;
    ndev_d       = ndev_q;
    nharm_d      = nharm_q;
    hval_d       = hval_q;
    out_valid_d  = out_valid_q && out_stall_i;
    o_cnt_d      = o_cnt_q;
    o_dev_d      = o_dev_q;
    o_mean_d     = o_mean_q;
    o_quad_d     = o_quad_q;
    o_harm_d     = o_harm_q;
    o_hval_d     = o_hval_q;
    div_start    = 1'b0;
    div_num      = acc_sum;
    div_den      = DW'(n_q);
    sq_start     = 1'b0;
    sq_val       = wide_q;
    cur_cnt      = first_q ? {16'd0, seed_count_q} : cnt_q;
    cur_mean     = first_q ? seed_mean_q : mean_q;
    cur_dev      = first_q ? seed_dev_q : dev_q;
    cur_harm     = first_q ? seed_harm_q : harm_q;

    if (cfg_wr) begin
      unique case (rsu_pkg::rsu_reg_e'(paddr[3:2]))
        rsu_pkg::REG_SEED_COUNT:     seed_count_d = pwdata[15:0];
        rsu_pkg::REG_SEED_MEAN:      seed_mean_d  = pwdata;
        rsu_pkg::REG_SEED_HARMONIC:  seed_harm_d  = pwdata;
        rsu_pkg::REG_SEED_DEVIATION: seed_dev_d   = pwdata;
        default:                     seed_count_d = seed_count_q;
      endcase
    end

    if (state_q != ST_IDLE && state_q != ST_DE2 && state_q != ST_DMN &&
        state_q != ST_SQV && state_q != ST_DH && state_q != ST_SQW &&
        state_q != ST_OUT) begin
      acc_d = acc_sum;
      mk_d  = mk_q + 3'd1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          first_d = 1'b0;
          cnt_d   = cur_cnt;
          mean_d  = cur_mean;
          dev_d   = cur_dev;
          harm_d  = cur_harm;
          n_d     = (cur_cnt == 32'hFFFF_FFFF) ? cur_cnt : cur_cnt + 32'd1;
          m_d     = ((cur_cnt == 32'hFFFF_FFFF) ? cur_cnt : cur_cnt + 32'd1) - 32'd1;
          x_d     = {sample_value_i, FRAC_BITS'(0)};
          opa_d   = 96'(cur_dev);
          opb_d   = 64'(cur_dev);
          acc_d   = '0;
          mk_d    = '0;
          state_d = ST_MDD;
        end
      end
      ST_MDD: if (mac_last) begin
        opa_d = 96'(mean_q);
        opb_d = 64'(mean_q);
        mk_d  = '0;
        state_d = ST_MMM;
      end
      ST_MMM: if (mac_last) begin
        opa_d = acc_sum[95:0];
        opb_d = 64'(m_q);
        acc_d = '0;
        mk_d  = '0;
        state_d = ST_MSM;
      end
      ST_MSM: if (mac_last) begin
        opa_d = 96'(x_q);
        opb_d = 64'(x_q);
        mk_d  = '0;
        state_d = ST_MXX;
      end
      ST_MXX: if (mac_last) begin
        div_start = 1'b1;
        state_d   = ST_DE2;
      end
      ST_DE2: if (div_stat.done) begin
        wide_d  = div_quot;
        sq_val  = div_quot;
        sq_start = 1'b1;
        opa_d   = 96'(mean_q);
        opb_d   = 64'(m_q);
        acc_d   = AW'(x_q);
        mk_d    = '0;
        state_d = ST_MMN;
      end
      ST_MMN: if (mac_last) begin
        div_start = 1'b1;
        state_d   = ST_DMN;
      end
      ST_DMN: if (div_stat.done) begin
        nmean_d = sat32(div_quot);
        opa_d   = 96'(sat32(div_quot));
        opb_d   = 64'(sat32(div_quot));
        acc_d   = '0;
        mk_d    = '0;
        state_d = ST_MNN;
      end
      ST_MNN: if (mac_last) begin
        wide_d  = var_val;
        state_d = ST_SQV;
      end
      ST_SQV: if (!sq_stat.busy) begin
        quad_d   = sat32(AW'(sq_root));
        sq_start = 1'b1;
        opa_d    = 96'(n_q);
        opb_d    = 64'(harm_q);
        acc_d    = '0;
        mk_d     = '0;
        state_d  = ST_MNH;
      end
      ST_MNH: if (mac_last) begin
        opa_d = acc_sum[95:0];
        opb_d = 64'(x_q);
        acc_d = '0;
        mk_d  = '0;
        state_d = ST_MNX;
      end
      ST_MNX: if (mac_last) begin
        wide_d = acc_sum;
        opa_d  = 96'(m_q);
        opb_d  = 64'(x_q);
        acc_d  = AW'(harm_q);
        mk_d   = '0;
        state_d = ST_MDEN;
      end
      ST_MDEN: if (mac_last) begin
        hval_d  = !(seed_count_q == '0 && seed_harm_q == '0) && (x_q != '0) &&
                  (den_val != '0);
        nharm_d = harm_q;
        div_num = wide_q;
        div_den = den_val;
        if (!(seed_count_q == '0 && seed_harm_q == '0) && (x_q != '0) &&
            (den_val != '0)) begin
          div_start = 1'b1;
          state_d   = ST_DH;
        end else begin
          state_d = ST_SQW;
        end
      end
      ST_DH: if (div_stat.done) begin
        nharm_d = sat32(div_quot);
        state_d = ST_SQW;
      end
      ST_SQW: if (!sq_stat.busy) begin
        ndev_d  = sat32(AW'(sq_root));
        state_d = ST_OUT;
      end
      ST_OUT: if (!out_valid_q || !out_stall_i) begin
        out_valid_d = 1'b1;
        o_cnt_d     = n_q;
        o_dev_d     = ndev_q;
        o_mean_d    = nmean_q;
        o_quad_d    = quad_q;
        o_harm_d    = nharm_q;
        o_hval_d    = hval_q;
        cnt_d       = n_q;
        mean_d      = nmean_q;
        dev_d       = ndev_q;
        harm_d      = nharm_q;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      seed_count_q <= '0;
      seed_mean_q  <= '0;
      seed_harm_q  <= '0;
      seed_dev_q   <= '0;
      first_q      <= 1'b1;
      cnt_q        <= '0;
      mean_q       <= '0;
      dev_q        <= '0;
      harm_q       <= '0;
      mk_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      seed_count_q <= seed_count_d;
      seed_mean_q  <= seed_mean_d;
      seed_harm_q  <= seed_harm_d;
      seed_dev_q   <= seed_dev_d;
      first_q      <= first_d;
      cnt_q        <= cnt_d;
      mean_q       <= mean_d;
      dev_q        <= dev_d;
      harm_q       <= harm_d;
      mk_q         <= mk_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    m_q      <= m_d;
    x_q      <= x_d;
    opa_q    <= opa_d;
    opb_q    <= opb_d;
    acc_q    <= acc_d;
    wide_q   <= wide_d;
    nmean_q  <= nmean_d;
    quad_q   <= quad_d;
    ndev_q   <= ndev_d;
    nharm_q  <= nharm_d;
    hval_q   <= hval_d;
    o_cnt_q  <= o_cnt_d;
    o_dev_q  <= o_dev_d;
    o_mean_q <= o_mean_d;
    o_quad_q <= o_quad_d;
    o_harm_q <= o_harm_d;
    o_hval_q <= o_hval_d;
  end

  assign out_valid_o     = out_valid_q;
  assign sample_count_o  = o_cnt_q;
  assign std_deviation_o = o_dev_q;
  assign arith_mean_o    = o_mean_q;
  assign quad_mean_o     = o_quad_q;
  assign harm_mean_o     = o_harm_q;
  assign harm_valid_o    = o_hval_q;

  `RSU_ASSERT_IMPL(a_out_from_final, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ST_OUT), "result beat raised outside final step")
  `RSU_ASSERT_IMPL(a_div_idle_start, clk_i, rst_ni, div_start, !div_stat.busy, "divider restarted while busy")
  `RSU_ASSERT_IMPL(a_sqrt_idle_start, clk_i, rst_ni, sq_start, !sq_stat.busy, "root unit restarted while busy")
  `RSU_ASSERT_IMPL(a_count_nonzero, clk_i, rst_ni, out_valid_q, o_cnt_q != 32'd0, "result count is zero")
  `RSU_ASSERT_NEXT(a_seeds_consumed, clk_i, rst_ni, in_acc, !first_q, "seeds not consumed on accept")

endmodule

[tb/tb_running_statistics_update_unit.sv]
// Testbench for running_statistics_update_unit: APB seed writes, a sample stream, and
// a checker that compares every result beat with a fixed-point predictor.
// Depends on rsu_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_running_statistics_update_unit;

  typedef struct {
    bit [31:0] cnt;
    bit [31:0] dev;
    bit [31:0] mean;
    bit [31:0] quad;
    bit [31:0] harm;
    bit        hv;
  } stats_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] sample_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] sample_count_o, std_deviation_o, arith_mean_o, quad_mean_o, harm_mean_o;
  logic        harm_valid_o;

  running_statistics_update_unit i_dut (.*);

  stats_t    expected_stats[$];
  int        errors = 0;
  int        gap_pct = 0;
  int        stall_pct = 0;
  bit [31:0] reg_count, reg_mean, reg_harm, reg_dev;
  bit        seeds_pending = 1'b1;
  bit [31:0] run_count, run_mean, run_dev, run_harm;

  initial forever #4 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("running_statistics_update_unit verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic bit [31:0] sat32(bit [127:0] v);
    return (v > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic bit [127:0] root_floor(bit [127:0] v);
    bit [127:0] r;
    bit [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic stats_t update_stats(bit [15:0] s);
    stats_t     o;
    bit [127:0] x, n, m, mn, dv, h, e2, nm2, den;
    bit         ok;
    if (seeds_pending) begin
      run_count = reg_count; run_mean = reg_mean;
      run_dev = reg_dev; run_harm = reg_harm;
      seeds_pending = 1'b0;
    end
    x  = 128'(s) << 16;
    n  = (run_count == 32'hFFFF_FFFF) ? 128'hFFFF_FFFF : 128'(run_count) + 1;
    m  = n - 1;
    mn = run_mean; dv = run_dev; h = run_harm;
    e2 = ((dv * dv) * m + (mn * mn) * m + x * x) / n;
    o.quad = sat32(root_floor(e2));
    o.mean = sat32((mn * m + x) / n);
    nm2 = 128'(o.mean) * 128'(o.mean);
    o.dev = sat32(root_floor(e2 >= nm2 ? e2 - nm2 : 128'd0));
    ok  = !(reg_count == 0 && reg_harm == 0) && x != 0;
    den = m * x + h;
    if (den == 0) ok = 1'b0;
    o.harm = run_harm;
    if (ok) o.harm = sat32(((n * h) * x) / den);
    o.hv  = ok;
    o.cnt = n[31:0];
    run_count = n[31:0]; run_mean = o.mean; run_dev = o.dev; run_harm = o.harm;
    return o;
  endfunction

  always @(posedge clk_i) begin
    stats_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result beat, count %h", $time, sample_count_o);
        errors++;
      end else begin
        e = expected_stats.pop_front();
        if (sample_count_o !== e.cnt || std_deviation_o !== e.dev ||
            arith_mean_o !== e.mean || quad_mean_o !== e.quad ||
            harm_mean_o !== e.harm || harm_valid_o !== e.hv) begin
          $display("%0t: mismatch exp cnt %h dev %h mean %h quad %h harm %h hv %b",
                   $time, e.cnt, e.dev, e.mean, e.quad, e.harm, e.hv);
          $display("%0t:          act cnt %h dev %h mean %h quad %h harm %h hv %b",
                   $time, sample_count_o, std_deviation_o, arith_mean_o,
                   quad_mean_o, harm_mean_o, harm_valid_o);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(rsu_pkg::rsu_reg_e r, bit [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {r, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      rsu_pkg::REG_SEED_COUNT:     reg_count = {16'd0, v[15:0]};
      rsu_pkg::REG_SEED_MEAN:      reg_mean = v;
      rsu_pkg::REG_SEED_HARMONIC:  reg_harm = v;
      rsu_pkg::REG_SEED_DEVIATION: reg_dev = v;
      default:                     reg_dev = reg_dev;
    endcase
  endtask

  task automatic send_sample(bit [15:0] s);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 400)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_value_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    expected_stats.push_back(update_stats(s));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic bit [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(1, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_extreme_seeds();
    bit [15:0] vals[8] = '{16'hFFFF, 16'd0, 16'd1, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd0, 16'd2};
    write_reg(rsu_pkg::REG_SEED_COUNT, 32'hFFFF_FFFF);
    write_reg(rsu_pkg::REG_SEED_MEAN, 32'hFFFF_FFFF);
    write_reg(rsu_pkg::REG_SEED_HARMONIC, 32'hFFFF_FFFF);
    write_reg(rsu_pkg::REG_SEED_DEVIATION, 32'hFFFF_FFFF);
    foreach (vals[i]) send_sample(vals[i]);
    drain();
  endtask

  task automatic test_harmonic_invalid();
    write_reg(rsu_pkg::REG_SEED_COUNT, 32'd0);
    write_reg(rsu_pkg::REG_SEED_HARMONIC, 32'd0);
    write_reg(rsu_pkg::REG_SEED_MEAN, 32'd0);
    write_reg(rsu_pkg::REG_SEED_DEVIATION, 32'd0);
    repeat (6) send_sample(rand_sample());
    send_sample(16'hFFFF);
    drain();
    write_reg(rsu_pkg::REG_SEED_HARMONIC, 32'd1);
    repeat (4) send_sample(rand_sample());
    send_sample(16'd0);
    drain();
  endtask

  task automatic test_random(int gp, int sp, int count);
    gap_pct = gp; stall_pct = sp;
    write_reg(rsu_pkg::REG_SEED_COUNT, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
    write_reg(rsu_pkg::REG_SEED_HARMONIC, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
    for (int i = 0; i < count; i++) begin
      send_sample(rand_sample());
      if (i == count / 2) begin
        drain();
        stall_pct = (sp != 0) ? sp : 0;
      end
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extreme_seeds();
    test_harmonic_invalid();
    test_random(0, 0, 230);
    test_random(57, 0, 230);
    test_random(0, 57, 230);
    test_random(17, 17, 230);
    gap_pct = 0; stall_pct = 0;
    if (errors == 0) begin
      $display("running_statistics_update_unit verification clean");
    end else begin
      $display("running_statistics_update_unit verification failed");
    end
    $finish;
  end
endmodule
